[design/bpq_pkg.sv]
package bpq_pkg;

  localparam int unsigned BYTE_W     = 24;
  localparam int unsigned PLIMIT_W   = 7;
  localparam int unsigned CNT32_W    = 32;
  localparam int unsigned CNT48_W    = 48;
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned STATUS_W   = 3;

  localparam logic [PLIMIT_W-1:0] PLIMIT_RESET = 7'd64;
  localparam logic [BYTE_W-1:0]   BLIMIT_RESET = 24'd65536;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_START = 3'd3,
    REQ_STOP  = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_EMPTY_PKT      = 3'd1,
    ST_STOPPED        = 3'd2,
    ST_TOO_LARGE      = 3'd3,
    ST_POP_EMPTY_RUN  = 3'd4,
    ST_POP_EMPTY_STOP = 3'd5
  } status_e;

  typedef enum logic {
    REG_PACKET_LIMIT = 1'b0,
    REG_BYTE_LIMIT   = 1'b1
  } reg_e;

  typedef struct packed {
    logic rx_inc;
    logic drop_inc;
  } stat_cmd_t;

  function automatic logic [CNT32_W-1:0] sat_inc32(input logic [CNT32_W-1:0] a);
    logic [CNT32_W:0] s;
    s = {1'b0, a} + {{CNT32_W{1'b0}}, 1'b1};
    return s[CNT32_W] ? {CNT32_W{1'b1}} : s[CNT32_W-1:0];
  endfunction

  function automatic logic [CNT48_W-1:0] sat_add48(input logic [CNT48_W-1:0] a,
                                                   input logic [CNT48_W-1:0] b);
    logic [CNT48_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT48_W] ? {CNT48_W{1'b1}} : s[CNT48_W-1:0];
  endfunction

endpackage

[design/bpq_ram.sv]
module bpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/bpq_stats.sv]
module bpq_stats #(
  parameter int unsigned LEN_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bpq_pkg::stat_cmd_t     cmd_i,
  input  logic [LEN_WIDTH-1:0]   rx_len_i,
  input  logic [LEN_WIDTH-1:0]   drop_len_i,
  output logic [31:0]            rx_pkt_o,
  output logic [47:0]            rx_byte_o,
  output logic [31:0]            drop_pkt_o,
  output logic [47:0]            drop_byte_o
);
  import bpq_pkg::*;

  logic [CNT32_W-1:0] rx_pkt_q, drop_pkt_q;
  logic [CNT48_W-1:0] rx_byte_q, drop_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_pkt_q    <= '0;
      rx_byte_q   <= '0;
      drop_pkt_q  <= '0;
      drop_byte_q <= '0;
    end else begin
      if (cmd_i.rx_inc) begin
        rx_pkt_q  <= sat_inc32(rx_pkt_q);
        rx_byte_q <= sat_add48(rx_byte_q, CNT48_W'(rx_len_i));
      end
      if (cmd_i.drop_inc) begin
        drop_pkt_q  <= sat_inc32(drop_pkt_q);
        drop_byte_q <= sat_add48(drop_byte_q, CNT48_W'(drop_len_i));
      end
    end
  end

  assign rx_pkt_o    = rx_pkt_q;
  assign rx_byte_o   = rx_byte_q;
  assign drop_pkt_o  = drop_pkt_q;
  assign drop_byte_o = drop_byte_q;

endmodule

[design/bounded_packet_queue_drop_oldest.sv]
// Steps: start, empty push, stopped push and unknown requests go from accept straight to the finish state;
// pop reads the head entry first; push loops over a check and a drop of the head entry while it must make
// room; clear and stop drop every held entry the same way. Each drop is one ring read plus update.
// Items are worked one at a time; a result waits in the finish state while the output is stalled.
// Reset (async, active low): queue empty, pointers zero, stopped, stat counters zero,
// packet limit 64, byte limit 65536; ring contents are not cleared.
module bounded_packet_queue_drop_oldest #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned LEN_WIDTH   = 16,
  parameter int unsigned TAG_WIDTH   = 16,
  localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned IN_W   = ((LEN_WIDTH + TAG_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = TAG_WIDTH + LEN_WIDTH + CW + 24 + 32 + 48 + 32 + 48,
  localparam int unsigned OUT_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // pkt_len, pkt_tag
  input  logic [2:0]       s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // out_tag, out_len, held packets, held bytes, rx packet total,
  // rx byte total, drop packet total, drop byte total
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic [2:0]       m_axis_tuser,   // status
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [23:0]      cfg_data_i
);
  import bpq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PW = (CW > PLIMIT_W) ? CW : PLIMIT_W;
  localparam int unsigned SW = ((LEN_WIDTH > BYTE_W) ? LEN_WIDTH : BYTE_W) + 1;
  localparam int unsigned DW = LEN_WIDTH + TAG_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_DROP,
    S_POP,
    S_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]       count_q, count_d;
  logic [BYTE_W-1:0]   held_q, held_d;
  logic                running_q, running_d;
  logic                flush_q, flush_d;
  logic                out_valid_q, out_valid_d;
  logic [PLIMIT_W-1:0] plimit_q;
  logic [BYTE_W-1:0]   blimit_q;

  // item payload and result fields
  logic [LEN_WIDTH-1:0] len_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [LEN_WIDTH-1:0] res_len_q, res_len_d;
  logic [TAG_WIDTH-1:0] res_tag_q, res_tag_d;
  status_e              status_q, status_d;
  logic [OUT_W-1:0]     out_data_q;
  logic [2:0]           out_user_q;

  logic                 accept;
  logic [LEN_WIDTH-1:0] in_len;
  logic [TAG_WIDTH-1:0] in_tag;
  logic [PW-1:0]        plim;
  logic [BYTE_W-1:0]    blim;
  logic [SW-1:0]        held_plus;
  logic                 need_drop, too_large, out_load;

  logic                 ram_we, ram_re;
  logic [DW-1:0]        ram_rdata;
  logic [LEN_WIDTH-1:0] rd_len;
  logic [TAG_WIDTH-1:0] rd_tag;

  stat_cmd_t            stat_cmd;
  logic [LEN_WIDTH-1:0] drop_len;
  logic [31:0]          rx_pkt, drop_pkt;
  logic [47:0]          rx_byte, drop_byte;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_len = s_axis_tdata[LEN_WIDTH-1:0];
  assign in_tag = s_axis_tdata[LEN_WIDTH +: TAG_WIDTH];
  assign rd_tag = ram_rdata[TAG_WIDTH-1:0];
  assign rd_len = ram_rdata[TAG_WIDTH +: LEN_WIDTH];

  // effective limits
  always_comb begin
    plim = PW'(plimit_q);
    if (plim == '0) begin
      plim = PW'(1);
    end else if (plim > PW'(QUEUE_DEPTH)) begin
      plim = PW'(QUEUE_DEPTH);
    end
    blim = (blimit_q == '0) ? BYTE_W'(1) : blimit_q;
  end

  assign held_plus = SW'(held_q) + SW'(len_q);
  assign too_large = SW'(len_q) > SW'(blim);
  assign need_drop = (count_q != '0) &&
                     (flush_q || (PW'(count_q) >= plim) || (held_plus > SW'(blim)));

  // ring writes and reads never overlap in time: one item at a time, each access
  // finishes before the next one is issued
  assign ram_re = (state_q == S_LOOP && need_drop) ||
                  (accept && s_axis_tuser == REQ_POP && count_q != '0);
  assign ram_we = (state_q == S_LOOP) && !need_drop && !flush_q && !too_large;

  bpq_ram #(
    .WIDTH (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i ({len_q, tag_q}),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    held_d      = held_q;
    running_d   = running_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    res_tag_d   = res_tag_q;
    res_len_d   = res_len_q;
    stat_cmd    = '0;
    drop_len    = len_q;
    out_load    = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_tag_d = '0;
          res_len_d = '0;
          status_d  = ST_OK;
          drop_len  = in_len;
          state_d   = S_FIN;
          case (s_axis_tuser)
            REQ_PUSH: begin
              if (in_len == '0) begin
                status_d = ST_EMPTY_PKT;
              end else begin
                stat_cmd.rx_inc = 1'b1;
                if (!running_q) begin
                  stat_cmd.drop_inc = 1'b1;
                  status_d          = ST_STOPPED;
                end else begin
                  flush_d = 1'b0;
                  state_d = S_LOOP;
                end
              end
            end
            REQ_POP: begin
              if (count_q == '0) begin
                status_d = running_q ? ST_POP_EMPTY_RUN : ST_POP_EMPTY_STOP;
              end else begin
                state_d = S_POP;
              end
            end
            REQ_CLEAR: begin
              flush_d = 1'b1;
              state_d = S_LOOP;
            end
            REQ_START: begin
              running_d = 1'b1;
            end
            REQ_STOP: begin
              running_d = 1'b0;
              flush_d   = 1'b1;
              state_d   = S_LOOP;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_LOOP: begin
        if (need_drop) begin
          state_d = S_DROP;
        end else begin
          state_d = S_FIN;
          if (!flush_q) begin
            if (too_large) begin
              stat_cmd.drop_inc = 1'b1;
              status_d          = ST_TOO_LARGE;
            end else begin
              tail_d  = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
              count_d = count_q + CW'(1);
              held_d  = held_q + BYTE_W'(len_q);
            end
          end
        end
      end
      S_DROP: begin
        // head entry is on the read port: drop it and retry
        drop_len          = rd_len;
        stat_cmd.drop_inc = 1'b1;
        held_d  = (SW'(held_q) >= SW'(rd_len)) ? held_q - BYTE_W'(rd_len) : '0;
        head_d  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
        count_d = count_q - CW'(1);
        state_d = S_LOOP;
      end
      S_POP: begin
        res_tag_d = rd_tag;
        res_len_d = rd_len;
        held_d  = (SW'(held_q) >= SW'(rd_len)) ? held_q - BYTE_W'(rd_len) : '0;
        head_d  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
        count_d = count_q - CW'(1);
        state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the output slot is free
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      held_q      <= '0;
      running_q   <= 1'b0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
      plimit_q    <= PLIMIT_RESET;
      blimit_q    <= BLIMIT_RESET;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      held_q      <= held_d;
      running_q   <= running_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PACKET_LIMIT: plimit_q <= cfg_data_i[PLIMIT_W-1:0];
          REG_BYTE_LIMIT:   blimit_q <= cfg_data_i[BYTE_W-1:0];
          default:          plimit_q <= plimit_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    res_tag_q <= res_tag_d;
    res_len_q <= res_len_d;
    if (accept) begin
      len_q <= in_len;
      tag_q <= in_tag;
    end
    if (out_load) begin
      out_data_q <= OUT_W'({drop_byte, drop_pkt, rx_byte, rx_pkt, held_q, count_q,
                            res_len_q, res_tag_q});
      out_user_q <= status_q;
    end
  end

  bpq_stats #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (stat_cmd),
    .rx_len_i    (in_len),
    .drop_len_i  (drop_len),
    .rx_pkt_o    (rx_pkt),
    .rx_byte_o   (rx_byte),
    .drop_pkt_o  (drop_pkt),
    .drop_byte_o (drop_byte)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign cfg_ready_o   = 1'b1;

endmodule

[design/bpq_checker.sv]
module bpq_checker #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned LEN_WIDTH   = 16,
  parameter int unsigned TAG_WIDTH   = 16,
  localparam int unsigned CW       = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_BITS = TAG_WIDTH + LEN_WIDTH + CW + 24 + 32 + 48 + 32 + 48,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [2:0]       m_axis_tuser
);
  import bpq_pkg::*;

  localparam int unsigned FW = TAG_WIDTH + LEN_WIDTH;

  logic [CW-1:0] queued;
  assign queued = m_axis_tdata[FW +: CW];

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after an accept");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> queued <= CW'(QUEUE_DEPTH))
    else $error("queued packets above depth");

  a_no_payload_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[FW-1:0] == '0)
    else $error("tag or length on a result that is not ok");

  a_pop_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_POP_EMPTY_RUN || m_axis_tuser == ST_POP_EMPTY_STOP)
    |-> queued == '0)
    else $error("pop reported empty with packets held");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind bounded_packet_queue_drop_oldest bpq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .LEN_WIDTH   (LEN_WIDTH),
  .TAG_WIDTH   (TAG_WIDTH)
) u_bpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
